FILE: sv/rht_pkg.sv
// Shared types and constants for the reference-counted handle table.
// Used by rht_ctrl, rht_dp and refcounted_handle_table_top.
package rht_pkg;

    localparam int ENTRIES = 256;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;
    localparam logic [31:0] MAX_VAL = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_NEW    = 2'd0,
        OP_REF    = 2'd1,
        OP_UNREF  = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_INVALID   = 3'd2,
        ST_EXHAUSTED = 3'd3,
        ST_OVERFLOW  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [31:0] context_tok;
        logic        notify;
        logic [31:0] count;
        logic [31:0] data;
        logic [31:0] handle;
    } entry_t;

    localparam int ENT_W = $bits(entry_t);

    typedef struct packed {
        logic load;
        logic scan;
        logic exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hit;
        logic scan_done;
    } ctrl_sts_t;

endpackage

FILE: sv/rht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: sv/rht_ctrl.sv
// Controller state machine for the handle table: accept, scan, execute, deliver.
// Depends on rht_pkg.
module rht_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output rht_pkg::ctrl_cmd_t cmd,
    input  rht_pkg::ctrl_sts_t sts
);

    rht_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rht_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            rht_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = rht_pkg::S_SCAN;
                end
            end
            rht_pkg::S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.hit || sts.scan_done) begin
                    state_next = rht_pkg::S_EXEC;
                end
            end
            rht_pkg::S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = rht_pkg::S_OUT;
            end
            rht_pkg::S_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = rht_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rht_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/rht_dp.sv
// Datapath for the handle table: entry RAM, live bits, scan pipeline, handle counter
// and result registers. Depends on rht_pkg and rht_ram.
module rht_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  rht_pkg::ctrl_cmd_t  cmd,
    output rht_pkg::ctrl_sts_t  sts,
    input  rht_pkg::op_t        in_op,
    input  logic [31:0]         in_handle,
    input  logic [31:0]         in_data,
    input  logic                in_notify,
    input  logic [31:0]         in_context,
    output rht_pkg::status_t    status_out,
    output logic [31:0]         handle_out,
    output logic [31:0]         data_out,
    output logic [31:0]         count_out,
    output logic                release_res,
    output logic [31:0]         release_context_out
);

    // captured request
    rht_pkg::op_t op_reg;
    logic [31:0]  handle_reg;
    logic [31:0]  data_reg;
    logic         notify_reg;
    logic [31:0]  context_reg;

    // scan pipeline
    logic [rht_pkg::CNT_W-1:0] issue_cnt_reg;
    logic                      issue_ok;
    logic                      cmp_vld_reg;
    logic [rht_pkg::IDX_W-1:0] cmp_idx_reg;
    logic                      cmp_live_reg;
    logic                      hit;

    logic [rht_pkg::ENTRIES-1:0] live_reg;
    logic [rht_pkg::ENTRIES-1:0] live_next;
    logic [31:0]                 last_handle_reg;
    logic [31:0]                 last_handle_next;

    logic                      found_reg;
    logic [rht_pkg::IDX_W-1:0] found_idx_reg;
    rht_pkg::entry_t           found_ent_reg;

    logic                   ram_we;
    rht_pkg::entry_t        ram_wdata;
    logic [rht_pkg::ENT_W-1:0] ram_rdata;
    rht_pkg::entry_t        rd_ent;

    rht_pkg::status_t status_next;
    logic [31:0]      handle_out_next;
    logic [31:0]      data_out_next;
    logic [31:0]      count_out_next;
    logic             release_next;
    logic [31:0]      rctx_next;

    rht_pkg::status_t status_reg;
    logic [31:0]      handle_out_reg;
    logic [31:0]      data_out_reg;
    logic [31:0]      count_out_reg;
    logic             release_reg;
    logic [31:0]      rctx_reg;

    rht_ram #(
        .WIDTH (rht_pkg::ENT_W),
        .DEPTH (rht_pkg::ENTRIES)
    ) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .wr_addr (found_idx_reg),
        .wr_data (ram_wdata),
        .rd_addr (issue_cnt_reg[rht_pkg::IDX_W-1:0]),
        .rd_data (ram_rdata)
    );

    assign rd_ent   = rht_pkg::entry_t'(ram_rdata);
    assign issue_ok = cmd.scan && (issue_cnt_reg < rht_pkg::CNT_W'(rht_pkg::ENTRIES));

    always_comb begin
        if (op_reg == rht_pkg::OP_NEW) begin
            hit = cmp_vld_reg && !cmp_live_reg;
        end else begin
            hit = cmp_vld_reg && cmp_live_reg && (rd_ent.handle == handle_reg);
        end
    end

    assign sts.hit       = hit;
    assign sts.scan_done = cmp_vld_reg &&
                           (cmp_idx_reg == rht_pkg::IDX_W'(rht_pkg::ENTRIES - 1));

    assign status_out          = status_reg;
    assign handle_out          = handle_out_reg;
    assign data_out            = data_out_reg;
    assign count_out           = count_out_reg;
    assign release_res         = release_reg;
    assign release_context_out = rctx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= in_op;
            handle_reg  <= in_handle;
            data_reg    <= in_data;
            notify_reg  <= in_notify;
            context_reg <= in_context;
        end
        cmp_idx_reg  <= issue_cnt_reg[rht_pkg::IDX_W-1:0];
        cmp_live_reg <= live_reg[issue_cnt_reg[rht_pkg::IDX_W-1:0]];
        if (cmd.scan && hit) begin
            found_idx_reg <= cmp_idx_reg;
            found_ent_reg <= rd_ent;
        end
        if (cmd.exec) begin
            status_reg     <= status_next;
            handle_out_reg <= handle_out_next;
            data_out_reg   <= data_out_next;
            count_out_reg  <= count_out_next;
            release_reg    <= release_next;
            rctx_reg       <= rctx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_cnt_reg   <= '0;
            cmp_vld_reg     <= 1'b0;
            found_reg       <= 1'b0;
            live_reg        <= '0;
            last_handle_reg <= '0;
        end else begin
            cmp_vld_reg     <= issue_ok;
            live_reg        <= live_next;
            last_handle_reg <= last_handle_next;
            if (cmd.load) begin
                issue_cnt_reg <= '0;
                found_reg     <= 1'b0;
            end else begin
                if (issue_ok) begin
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                end
                if (cmd.scan && hit) begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        live_next        = live_reg;
        last_handle_next = last_handle_reg;
        ram_we           = 1'b0;
        ram_wdata        = found_ent_reg;
        status_next      = rht_pkg::ST_OK;
        handle_out_next  = '0;
        data_out_next    = '0;
        count_out_next   = '0;
        release_next     = 1'b0;
        rctx_next        = '0;
        if (cmd.exec) begin
            if (op_reg == rht_pkg::OP_NEW) begin
                if (!found_reg) begin
                    status_next = rht_pkg::ST_FULL;
                end else if (last_handle_reg == rht_pkg::MAX_VAL) begin
                    status_next = rht_pkg::ST_EXHAUSTED;
                end else begin
                    last_handle_next      = last_handle_reg + 32'd1;
                    ram_we                = 1'b1;
                    ram_wdata.handle      = last_handle_reg + 32'd1;
                    ram_wdata.data        = data_reg;
                    ram_wdata.count       = 32'd1;
                    ram_wdata.notify      = notify_reg;
                    ram_wdata.context_tok = context_reg;
                    live_next[found_idx_reg] = 1'b1;
                    handle_out_next       = last_handle_reg + 32'd1;
                    count_out_next        = 32'd1;
                end
            end else if (!found_reg) begin
                status_next = rht_pkg::ST_INVALID;
            end else begin
                case (op_reg)
                    rht_pkg::OP_REF: begin
                        if (found_ent_reg.count == rht_pkg::MAX_VAL) begin
                            status_next    = rht_pkg::ST_OVERFLOW;
                            count_out_next = found_ent_reg.count;
                        end else begin
                            ram_we          = 1'b1;
                            ram_wdata.count = found_ent_reg.count + 32'd1;
                            count_out_next  = found_ent_reg.count + 32'd1;
                        end
                    end
                    rht_pkg::OP_UNREF: begin
                        ram_we          = 1'b1;
                        ram_wdata.count = found_ent_reg.count - 32'd1;
                        count_out_next  = found_ent_reg.count - 32'd1;
                        if (found_ent_reg.count == 32'd1) begin
                            live_next[found_idx_reg] = 1'b0;
                            data_out_next = found_ent_reg.data;
                            release_next  = found_ent_reg.notify;
                            if (found_ent_reg.notify) begin
                                rctx_next = found_ent_reg.context_tok;
                            end
                        end
                    end
                    default: begin
                        data_out_next  = found_ent_reg.data;
                        count_out_next = found_ent_reg.count;
                    end
                endcase
            end
        end
    end

endmodule

FILE: sv/refcounted_handle_table_top.sv
// Reference-counted handle table: one request transfer in, one result transfer out.
// Requests are taken one at a time. Each passes through an accept step, a scan of the
// entry table at one entry per cycle through the entry RAM's read port (stopping at the
// first free slot for new or the matching live handle otherwise), an execute step, and
// then the result is held until it is taken. Live bits clear at reset, so no clearing
// pass is needed.
// Depends on rht_pkg, rht_ctrl, rht_dp.
module refcounted_handle_table_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,  // op[1:0] handle[33:2] data_in[65:34] notify_on_free[66]
                                   // release_context[98:67], zero above
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata   // status[2:0] handle_out[34:3] data_out[66:35]
                                   // count_out[98:67] release_res[99]
                                   // release_context_out[131:100], zero above
);

    rht_pkg::ctrl_cmd_t cmd;
    rht_pkg::ctrl_sts_t sts;
    rht_pkg::status_t   status;
    logic [31:0]        handle_out;
    logic [31:0]        data_out;
    logic [31:0]        count_out;
    logic               release_res;
    logic [31:0]        release_context_out;

    rht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    rht_dp u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .in_op               (rht_pkg::op_t'(s_tdata[1:0])),
        .in_handle           (s_tdata[33:2]),
        .in_data             (s_tdata[65:34]),
        .in_notify           (s_tdata[66]),
        .in_context          (s_tdata[98:67]),
        .status_out          (status),
        .handle_out          (handle_out),
        .data_out            (data_out),
        .count_out           (count_out),
        .release_res         (release_res),
        .release_context_out (release_context_out)
    );

    assign m_tdata = {4'b0, release_context_out, release_res, count_out, data_out,
                      handle_out, status};

endmodule
